### src/smlk_pkg.sv
// Package with the sizes, codes and record types of the socket best-match lookup.
`default_nettype none

package smlk_pkg;

    localparam int NUM_ENTRIES = 64;
    localparam int NUM_GROUPS  = 16;

    localparam int ENTRY_W = $clog2(NUM_ENTRIES);
    localparam int CNT_W   = $clog2(NUM_ENTRIES + 1);
    localparam int GROUP_W = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;

    localparam int ADDR_W       = 32;
    localparam int PORT_W       = 16;
    localparam int FIELD_IDX_W  = 6;
    localparam int FIELD_SIZE_W = 7;
    localparam int CLASS_W      = 2;

    localparam int GRP_CMP_W = $clog2(NUM_GROUPS + 1);
    localparam int CMP_A_W   = (CNT_W > FIELD_SIZE_W) ? CNT_W : FIELD_SIZE_W;
    localparam int CMP_W     = (CMP_A_W > GRP_CMP_W) ? CMP_A_W : GRP_CMP_W;

    typedef enum logic [1:0] {
        ACT_WR_ENTRY = 2'd0,
        ACT_WR_GROUP = 2'd1,
        ACT_LOOKUP   = 2'd2,
        ACT_NONE     = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } t_state;

    localparam logic [CLASS_W-1:0] CLASS_EXACT     = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_ADDR_ONLY = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_PORT_ONLY = 2'd2;
    localparam logic [CLASS_W-1:0] CLASS_WILDCARD  = 2'd3;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [PORT_W-1:0] port;
        logic              ip_any;
        logic              active;
        logic              rx;
    } t_entry;

    typedef struct packed {
        logic               en;
        logic [ENTRY_W-1:0] addr;
        t_entry             data;
    } t_entry_wr;

    typedef struct packed {
        logic               en;
        logic [ENTRY_W-1:0] addr;
    } t_entry_rd;

endpackage

`default_nettype wire

### src/smlk_if.sv
// Request and result channel interfaces of the socket best-match lookup.
`default_nettype none

interface smlk_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [5:0]  index;
    logic [31:0] ip_addr;
    logic [15:0] port;
    logic        ip_any;
    logic        entry_active;
    logic        rx_configured;
    logic [5:0]  group_first;
    logic [6:0]  group_size;
    logic [5:0]  preferred_id;
    logic        preferred_given;

    modport source (
        output valid, action, index, ip_addr, port, ip_any, entry_active,
               rx_configured, group_first, group_size, preferred_id, preferred_given,
        input  ready
    );
    modport sink (
        input  valid, action, index, ip_addr, port, ip_any, entry_active,
               rx_configured, group_first, group_size, preferred_id, preferred_given,
        output ready
    );
endinterface

interface smlk_out_if;
    logic       valid;
    logic       ready;
    logic       found;
    logic [5:0] match_index;
    logic [1:0] match_class;

    modport source (output valid, found, match_index, match_class, input ready);
    modport sink (input valid, found, match_index, match_class, output ready);
endinterface

`default_nettype wire

### src/smlk_entry_store.sv
// Connection table memory with per-entry valid bits and a registered read port.
`default_nettype none

module smlk_entry_store import smlk_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_entry_wr i_wr,
    input  wire t_entry_rd i_rd,
    output t_entry         o_rd_data
);

    t_entry               r_mem [NUM_ENTRIES];
    logic [NUM_ENTRIES-1:0] r_vld;
    t_entry               r_rd_data;
    logic                 r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_vld[i_wr.addr] <= 1'b1;
            end
            if (i_rd.en) begin
                r_rd_vld <= r_vld[i_rd.addr];
            end
        end
    end

    // An entry never written reads as the reset value, which is inactive.
    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

`default_nettype wire

### src/socket_best_match_lookup_top.sv
// Top level of the socket best-match lookup: group table, walk control and result register.
//
//   Channel  Dir  Modport  Beat
//   i_req    in   sink     write entry, write group or lookup request
//   o_res    out  source   found, match_index, match_class (zero for writes)
//
// A write passes through the finish state to the result register; a lookup first walks
// the entries of its group (none for an empty group), and an exact hit can end the
// walk early.
// The walk reads the connection table one entry per cycle through its single read port.
// Synchronous reset clears the group table and the table's valid bits at once.
// A result waits in its register while the next beat is taken; only the
// hand-over of a further result waits for that register to empty.
`default_nettype none

module socket_best_match_lookup_top import smlk_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    smlk_in_if.sink   i_req,
    smlk_out_if.source o_res
);

    t_state r_state, n_state;

    logic [ENTRY_W-1:0] r_grp_base [NUM_GROUPS];
    logic [CNT_W-1:0]   r_grp_cnt  [NUM_GROUPS];

    logic [ADDR_W-1:0]      r_addr;
    logic [PORT_W-1:0]      r_port;
    logic [FIELD_IDX_W-1:0] r_pref;
    logic                   r_pref_given;
    logic [CNT_W-1:0]       r_rd_ptr;
    logic [CNT_W-1:0]       r_end;
    logic [ENTRY_W-1:0]     r_chk_ptr;
    logic                   r_chk_vld;
    logic                   r_have;
    logic                   r_exact;
    logic [ENTRY_W-1:0]     r_best;
    logic [CLASS_W-1:0]     r_best_class;
    logic                   r_best_rx;

    logic                   r_out_valid;
    logic                   r_out_found;
    logic [FIELD_IDX_W-1:0] r_out_index;
    logic [CLASS_W-1:0]     r_out_class;

    t_action   w_act;
    logic      w_in_acc;
    logic      w_in_ready;
    logic      w_out_free;
    logic      w_out_load;
    t_entry_wr w_wr;
    t_entry_rd w_rd;
    t_entry    w_ent;

    logic [GROUP_W-1:0] w_gidx;
    logic               w_grp_ok;
    logic               w_first_ok;
    logic [CMP_W-1:0]   w_room;
    logic [CMP_W-1:0]   w_size;
    logic [CNT_W-1:0]   w_grp_cnt_new;

    logic               w_more;
    logic               w_is_pref;
    logic               w_stop;
    logic               w_match;
    logic [CLASS_W-1:0] w_class;
    logic               w_tie_win;
    logic               w_take;

    assign w_act    = t_action'(i_req.action);
    assign w_in_acc = i_req.valid && w_in_ready;

    assign w_gidx     = GROUP_W'(i_req.index);
    assign w_grp_ok   = CMP_W'(i_req.index) < CMP_W'(NUM_GROUPS);
    assign w_first_ok = CMP_W'(i_req.group_first) < CMP_W'(NUM_ENTRIES);
    assign w_room     = CMP_W'(NUM_ENTRIES) - CMP_W'(i_req.group_first);
    assign w_size     = CMP_W'(i_req.group_size);

    always_comb begin
        w_grp_cnt_new = '0;
        if (w_first_ok) begin
            w_grp_cnt_new = (w_size < w_room) ? CNT_W'(w_size) : CNT_W'(w_room);
        end
    end

    always_comb begin
        w_wr.en          = w_in_acc && (w_act == ACT_WR_ENTRY)
                           && (CMP_W'(i_req.index) < CMP_W'(NUM_ENTRIES));
        w_wr.addr        = ENTRY_W'(i_req.index);
        w_wr.data.addr   = i_req.ip_addr;
        w_wr.data.port   = i_req.port;
        w_wr.data.ip_any = i_req.ip_any;
        w_wr.data.active = i_req.entry_active;
        w_wr.data.rx     = i_req.rx_configured;
    end

    smlk_entry_store u_entry_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_wr),
        .i_rd      (w_rd),
        .o_rd_data (w_ent)
    );

    assign w_more     = r_rd_ptr < r_end;
    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_is_pref  = r_pref_given && (CMP_W'(r_chk_ptr) == CMP_W'(r_pref));
    assign w_stop     = r_chk_vld && r_exact && !w_is_pref;

    always_comb begin
        w_match = w_ent.active;
        w_class = CLASS_WILDCARD;
        priority if ((w_ent.addr == r_addr) && (w_ent.port == r_port)) begin
            w_class = CLASS_EXACT;
        end else if ((w_ent.addr == r_addr) && (w_ent.port == '0)) begin
            w_class = CLASS_ADDR_ONLY;
        end else if (w_ent.ip_any && (w_ent.port == r_port)) begin
            w_class = CLASS_PORT_ONLY;
        end else if (w_ent.ip_any && (w_ent.port == '0)) begin
            w_class = CLASS_WILDCARD;
        end else begin
            w_match = 1'b0;
        end
    end

    assign w_tie_win = r_pref_given ? w_is_pref : (!r_best_rx && w_ent.rx);
    assign w_take    = r_chk_vld && !w_stop && w_match
                       && (!r_have || (w_class < r_best_class)
                           || ((w_class == r_best_class) && w_tie_win));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = (w_act == ACT_LOOKUP) ? ST_WALK : ST_FINISH;
                end
            end
            ST_WALK: begin
                if (w_stop || (!r_chk_vld && !w_more)) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_in_ready = 1'b0;
        w_out_load = 1'b0;
        w_rd.en    = 1'b0;
        w_rd.addr  = r_rd_ptr[ENTRY_W-1:0];
        unique case (r_state)
            ST_IDLE:   w_in_ready = 1'b1;
            ST_WALK:   w_rd.en    = w_more;
            ST_FINISH: w_out_load = w_out_free;
            default: begin
                w_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int g = 0; g < NUM_GROUPS; g++) begin
                r_grp_base[g] <= '0;
                r_grp_cnt[g]  <= '0;
            end
        end else if (w_in_acc && (w_act == ACT_WR_GROUP) && w_grp_ok) begin
            r_grp_base[w_gidx] <= ENTRY_W'(i_req.group_first);
            r_grp_cnt[w_gidx]  <= w_grp_cnt_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chk_vld <= 1'b0;
        end else begin
            r_chk_vld <= w_rd.en && !w_stop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_addr       <= i_req.ip_addr;
            r_port       <= i_req.port;
            r_pref       <= i_req.preferred_id;
            r_pref_given <= i_req.preferred_given;
            r_have       <= 1'b0;
            r_exact      <= 1'b0;
            r_best       <= '0;
            r_best_class <= CLASS_EXACT;
            r_best_rx    <= 1'b0;
            if ((w_act == ACT_LOOKUP) && w_grp_ok) begin
                r_rd_ptr <= CNT_W'(r_grp_base[w_gidx]);
                r_end    <= CNT_W'(r_grp_base[w_gidx]) + r_grp_cnt[w_gidx];
            end else begin
                r_rd_ptr <= '0;
                r_end    <= '0;
            end
        end else begin
            if (w_rd.en) begin
                r_rd_ptr  <= r_rd_ptr + CNT_W'(1);
                r_chk_ptr <= r_rd_ptr[ENTRY_W-1:0];
            end
            if (w_take) begin
                r_have       <= 1'b1;
                r_best       <= r_chk_ptr;
                r_best_class <= w_class;
                r_best_rx    <= w_ent.rx;
                if (w_class == CLASS_EXACT) begin
                    r_exact <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_found <= r_have;
            r_out_index <= FIELD_IDX_W'(r_best);
            r_out_class <= r_best_class;
        end
    end

    assign i_req.ready       = w_in_ready;
    assign o_res.valid       = r_out_valid;
    assign o_res.found       = r_out_found;
    assign o_res.match_index = r_out_index;
    assign o_res.match_class = r_out_class;

    a_ptr_in_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (r_rd_ptr <= r_end))
        else $error("Walk pointer ran past the end of the group.");

    a_exact_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_WALK) && r_exact) |-> (r_have && (r_best_class == CLASS_EXACT)))
        else $error("Exact flag set without an exact holder.");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> r_out_valid)
        else $error("Loaded result is not presented.");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_found) |-> ((r_out_index == '0) && (r_out_class == '0)))
        else $error("A result without a match carries nonzero fields.");

endmodule

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for the socket best-match lookup: directed and random traffic with a scoreboard.
`timescale 1ns / 100ps

module tb_top;
    import smlk_pkg::*;

    localparam int TOTAL_BEATS    = 450;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 80;
    localparam int NO_MATCH       = 4;

    typedef struct {
        t_action     action;
        logic [5:0]  index;
        logic [31:0] ip_addr;
        logic [15:0] port;
        logic        ip_any;
        logic        entry_active;
        logic        rx_configured;
        logic [5:0]  group_first;
        logic [6:0]  group_size;
        logic [5:0]  preferred_id;
        logic        preferred_given;
        bit          hold;
    } req_beat_t;

    typedef struct packed {
        logic       found;
        logic [5:0] conn;
        logic [1:0] cls;
    } match_t;

    logic i_clk;
    logic i_rst_n;

    smlk_in_if  req_ch ();
    smlk_out_if res_ch ();

    socket_best_match_lookup_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    // Shadow copy of the connection and group tables.
    logic [31:0] conn_addr [NUM_ENTRIES];
    logic [15:0] conn_port [NUM_ENTRIES];
    logic        conn_any  [NUM_ENTRIES];
    logic        conn_live [NUM_ENTRIES];
    logic        conn_rx   [NUM_ENTRIES];
    logic [5:0]  grp_base  [NUM_GROUPS];
    logic [6:0]  grp_len   [NUM_GROUPS];

    req_beat_t pending_beats[$];
    match_t    expected_matches[$];
    req_beat_t cur_beat;

    int mismatch_count;
    int beats_accepted;
    int results_seen;
    int lookup_count;
    int write_count;
    int class_hits [4];
    int quiet_cycles;
    int burst_left;
    int gap_left;
    int stall_mode;
    int mode_left;
    bit pause_next;
    bit drv_busy;
    bit drv_valid;
    match_t got_match;
    match_t want_match;

    task automatic flag_mismatch(string what, int unsigned want, int unsigned got);
        $display("%0t: %s mismatch: want %0h got %0h", $time, what, want, got);
        mismatch_count++;
    endtask

    function automatic match_t predict_match(req_beat_t b);
        match_t r;
        int     e;
        int     last;
        int     best;
        int     best_cls;
        int     cls;
        bit     have;
        bit     exact;
        bit     take;
        bit     addr_eq;
        r = '0;
        case (b.action)
            ACT_WR_ENTRY: begin
                write_count++;
                if (b.index < NUM_ENTRIES) begin
                    conn_addr[b.index] = b.ip_addr;
                    conn_port[b.index] = b.port;
                    conn_any[b.index]  = b.ip_any;
                    conn_live[b.index] = b.entry_active;
                    conn_rx[b.index]   = b.rx_configured;
                end
            end
            ACT_WR_GROUP: begin
                write_count++;
                if (b.index < NUM_GROUPS) begin
                    grp_base[b.index] = b.group_first;
                    if (b.group_first >= NUM_ENTRIES)
                        grp_len[b.index] = '0;
                    else if (int'(b.group_size) < NUM_ENTRIES - int'(b.group_first))
                        grp_len[b.index] = b.group_size;
                    else
                        grp_len[b.index] = 7'(NUM_ENTRIES - int'(b.group_first));
                end
            end
            ACT_LOOKUP: begin
                lookup_count++;
                if (b.index < NUM_GROUPS) begin
                    e = grp_base[b.index];
                    last = e + grp_len[b.index];
                    if (last > NUM_ENTRIES) last = NUM_ENTRIES;
                    have = 0;
                    exact = 0;
                    best = 0;
                    best_cls = 0;
                    while (e < last &&
                           (!exact || (b.preferred_given && e == b.preferred_id))) begin
                        if (conn_live[e]) begin
                            addr_eq = conn_addr[e] == b.ip_addr;
                            if (addr_eq && b.port == conn_port[e])
                                cls = CLASS_EXACT;
                            else if (addr_eq && conn_port[e] == 0)
                                cls = CLASS_ADDR_ONLY;
                            else if (conn_any[e] && b.port == conn_port[e])
                                cls = CLASS_PORT_ONLY;
                            else if (conn_any[e] && conn_port[e] == 0)
                                cls = CLASS_WILDCARD;
                            else
                                cls = NO_MATCH;
                            if (cls != NO_MATCH) begin
                                if (!have || cls < best_cls)
                                    take = 1;
                                else if (cls == best_cls)
                                    take = b.preferred_given ? (e == b.preferred_id)
                                                             : (!conn_rx[best] && conn_rx[e]);
                                else
                                    take = 0;
                                if (take) begin
                                    have = 1;
                                    best = e;
                                    best_cls = cls;
                                    if (cls == CLASS_EXACT) exact = 1;
                                end
                            end
                        end
                        e++;
                    end
                    if (have) begin
                        r.found = 1'b1;
                        r.conn = 6'(best);
                        r.cls = 2'(best_cls);
                        class_hits[best_cls]++;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic req_beat_t noise_beat();
        req_beat_t b;
        b.action          = t_action'($urandom_range(0, 3));
        b.index           = 6'($urandom_range(0, 63));
        b.ip_addr         = $urandom;
        b.port            = 16'($urandom);
        b.ip_any          = 1'($urandom_range(0, 1));
        b.entry_active    = 1'($urandom_range(0, 1));
        b.rx_configured   = 1'($urandom_range(0, 1));
        b.group_first     = 6'($urandom_range(0, 63));
        b.group_size      = 7'($urandom_range(0, 64));
        b.preferred_id    = 6'($urandom_range(0, 63));
        b.preferred_given = 1'($urandom_range(0, 1));
        b.hold            = 0;
        return b;
    endfunction

    function automatic void push_beat(req_beat_t b);
        b.hold = pause_next;
        pause_next = 0;
        pending_beats.push_back(b);
    endfunction

    function automatic void add_entry(int idx, logic [31:0] addr, logic [15:0] port,
                                      bit any, bit live, bit rx);
        req_beat_t b;
        b = noise_beat();
        b.action = ACT_WR_ENTRY;
        b.index = 6'(idx);
        b.ip_addr = addr;
        b.port = port;
        b.ip_any = any;
        b.entry_active = live;
        b.rx_configured = rx;
        push_beat(b);
    endfunction

    function automatic void add_group(int grp, int first, int size);
        req_beat_t b;
        b = noise_beat();
        b.action = ACT_WR_GROUP;
        b.index = 6'(grp);
        b.group_first = 6'(first);
        b.group_size = 7'(size);
        push_beat(b);
    endfunction

    function automatic void add_lookup(int grp, logic [31:0] addr, logic [15:0] port,
                                       int pref, bit given);
        req_beat_t b;
        b = noise_beat();
        b.action = ACT_LOOKUP;
        b.index = 6'(grp);
        b.ip_addr = addr;
        b.port = port;
        b.preferred_id = 6'(pref);
        b.preferred_given = given;
        push_beat(b);
    endfunction

    task automatic present_beat(req_beat_t b);
        req_ch.action          <= b.action;
        req_ch.index           <= b.index;
        req_ch.ip_addr         <= b.ip_addr;
        req_ch.port            <= b.port;
        req_ch.ip_any          <= b.ip_any;
        req_ch.entry_active    <= b.entry_active;
        req_ch.rx_configured   <= b.rx_configured;
        req_ch.group_first     <= b.group_first;
        req_ch.group_size      <= b.group_size;
        req_ch.preferred_id    <= b.preferred_id;
        req_ch.preferred_given <= b.preferred_given;
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.action = ACT_NONE;
        req_ch.index = '0;
        req_ch.ip_addr = '0;
        req_ch.port = '0;
        req_ch.ip_any = 1'b0;
        req_ch.entry_active = 1'b0;
        req_ch.rx_configured = 1'b0;
        req_ch.group_first = '0;
        req_ch.group_size = '0;
        req_ch.preferred_id = '0;
        req_ch.preferred_given = 1'b0;
        res_ch.ready = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Driver: bursts of beats from the pending queue with random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            drv_busy = 0;
            burst_left = 0;
            gap_left = 0;
        end else begin
            drv_busy = req_ch.valid;
            if (req_ch.valid && req_ch.ready) begin
                expected_matches.push_back(predict_match(cur_beat));
                beats_accepted++;
                drv_busy = 0;
            end
            if (drv_busy) begin
                drv_valid = 1;
            end else if (gap_left != 0) begin
                gap_left--;
                drv_valid = 0;
            end else if (pending_beats.size() != 0 &&
                         !(pending_beats[0].hold && expected_matches.size() != 0)) begin
                cur_beat = pending_beats.pop_front();
                present_beat(cur_beat);
                drv_valid = 1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                end else begin
                    burst_left--;
                end
            end else begin
                drv_valid = 0;
            end
            req_ch.valid <= drv_valid;
        end
    end

    // Result ready follows a pattern whose mode (always ready, random or mostly low) changes at random intervals.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            stall_mode = 0;
            mode_left = 0;
        end else begin
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 300);
            end else begin
                mode_left--;
            end
            case (stall_mode)
                0: res_ch.ready <= 1'b1;
                1: res_ch.ready <= 1'($urandom_range(0, 1));
                default: res_ch.ready <= ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    // Monitor: every result beat is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            results_seen++;
            got_match = {res_ch.found, res_ch.match_index, res_ch.match_class};
            if (expected_matches.size() == 0) begin
                flag_mismatch("unexpected result", 0, got_match);
            end else begin
                want_match = expected_matches.pop_front();
                if (got_match.found !== want_match.found)
                    flag_mismatch("found", want_match.found, got_match.found);
                if (got_match.conn !== want_match.conn)
                    flag_mismatch("match_index", want_match.conn, got_match.conn);
                if (got_match.cls !== want_match.cls)
                    flag_mismatch("match_class", want_match.cls, got_match.cls);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("socket_best_match_lookup_top regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [31:0] addr_pool [3];
        logic [15:0] port_pool [3];
        logic [31:0] addr;
        logic [15:0] port;
        int          round;
        int          base;
        int          n;
        int          grp;
        int          size;
        int          pref;
        int          i;

        for (i = 0; i < NUM_ENTRIES; i++) begin
            conn_addr[i] = '0;
            conn_port[i] = '0;
            conn_any[i] = 0;
            conn_live[i] = 0;
            conn_rx[i] = 0;
        end
        for (i = 0; i < NUM_GROUPS; i++) begin
            grp_base[i] = '0;
            grp_len[i] = '0;
        end
        for (i = 0; i < 4; i++) class_hits[i] = 0;
        mismatch_count = 0;
        beats_accepted = 0;
        results_seen = 0;
        lookup_count = 0;
        write_count = 0;
        quiet_cycles = 0;
        pause_next = 0;

        // Directed part: field extremes, every class, tie rules and range limits.
        add_lookup(0, 32'hFFFF_FFFF, 16'hFFFF, 0, 0);
        add_entry(0, 32'hFFFF_FFFF, 16'hFFFF, 0, 1, 0);
        add_entry(1, 32'hFFFF_FFFF, 16'h0000, 0, 1, 1);
        add_entry(2, 32'h0000_0000, 16'hFFFF, 1, 1, 0);
        add_entry(3, 32'h0000_0000, 16'h0000, 1, 1, 1);
        add_entry(4, 32'h0000_0005, 16'h0009, 0, 0, 1);
        add_entry(5, 32'h0000_0005, 16'h0000, 1, 1, 0);
        add_entry(6, 32'h0000_0005, 16'h0000, 1, 1, 1);
        add_entry(63, 32'h1234_5678, 16'd80, 0, 1, 1);
        add_group(0, 0, 7);
        add_group(15, 60, 64);
        add_group(40, 0, 64);
        add_lookup(0, 32'hFFFF_FFFF, 16'hFFFF, 0, 0);
        add_lookup(0, 32'hFFFF_FFFF, 16'hFFFF, 1, 1);
        add_lookup(0, 32'hFFFF_FFFF, 16'h0007, 0, 0);
        add_lookup(0, 32'h0000_0009, 16'hFFFF, 0, 0);
        add_lookup(0, 32'h0000_0009, 16'h0009, 0, 0);
        add_lookup(0, 32'h0000_0009, 16'h0009, 3, 1);
        add_lookup(0, 32'h0000_0005, 16'h0009, 5, 1);
        add_lookup(0, 32'h0000_0005, 16'h0009, 0, 0);
        add_lookup(15, 32'h1234_5678, 16'd80, 63, 1);
        add_lookup(40, 32'h1234_5678, 16'd80, 0, 0);
        add_group(1, 63, 0);
        add_lookup(1, 32'h1234_5678, 16'd80, 0, 0);
        begin
            req_beat_t b;
            b = noise_beat();
            b.action = ACT_NONE;
            push_beat(b);
        end

        // Random part: rounds that build a small neighborhood and then look it up.
        round = 0;
        while (pending_beats.size() < TOTAL_BEATS) begin
            round++;
            if (round == 4 || round == 20) pause_next = 1;
            for (i = 0; i < 3; i++) begin
                case ($urandom_range(0, 5))
                    0: addr_pool[i] = 32'h0000_0000;
                    1: addr_pool[i] = 32'hFFFF_FFFF;
                    default: addr_pool[i] = $urandom;
                endcase
                port_pool[i] = ($urandom_range(0, 5) == 0) ? 16'hFFFF : 16'($urandom);
            end
            base = $urandom_range(0, 63);
            n = $urandom_range(2, 10);
            for (i = 0; i < n; i++) begin
                if ($urandom_range(0, 19) == 0) begin
                    push_beat(noise_beat());
                end else begin
                    port = ($urandom_range(0, 2) == 0) ? 16'h0000
                                                       : port_pool[$urandom_range(0, 2)];
                    add_entry((base + i) & 63, addr_pool[$urandom_range(0, 2)], port,
                              $urandom_range(0, 2) == 0, $urandom_range(0, 4) != 0,
                              $urandom_range(0, 1));
                end
            end
            grp = $urandom_range(0, NUM_GROUPS - 1);
            case ($urandom_range(0, 9))
                0: size = 64;
                1: size = $urandom_range(0, 64);
                default: size = n + $urandom_range(0, 2);
            endcase
            add_group(grp, base, size);
            if ($urandom_range(0, 3) == 0)
                add_group($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 64));
            for (i = $urandom_range(4, 12); i > 0; i--) begin
                addr = ($urandom_range(0, 4) == 0) ? $urandom : addr_pool[$urandom_range(0, 2)];
                port = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                   : port_pool[$urandom_range(0, 2)];
                pref = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                   : (base + $urandom_range(0, n)) & 63;
                if ($urandom_range(0, 19) == 0)
                    push_beat(noise_beat());
                else
                    add_lookup(($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : grp,
                               addr, port, pref, $urandom_range(0, 1));
            end
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        n = pending_beats.size();
        do @(posedge i_clk);
        while (beats_accepted != n || expected_matches.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d beats in %0d rounds: %0d writes, %0d lookups.",
                 beats_accepted, round, write_count, lookup_count);
        $display("Hits by class exact/address/port/wildcard: %0d/%0d/%0d/%0d, results %0d.",
                 class_hits[0], class_hits[1], class_hits[2], class_hits[3], results_seen);
        if (mismatch_count == 0)
            $display("socket_best_match_lookup_top regression: pass");
        else
            $display("socket_best_match_lookup_top regression: fail");
        $finish;
    end

endmodule
